FILE: hdl/rc4_stream_cipher_unit_macros.svh
// Assertion shorthands shared by the cipher modules.
// Each expects i_clk and i_rst_n in scope; checks are off during reset.
`ifndef RC4_STREAM_CIPHER_UNIT_MACROS_SVH
`define RC4_STREAM_CIPHER_UNIT_MACROS_SVH

// Same-cycle implication
`define RC4_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define RC4_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/rc4_pkg.sv
`default_nettype none

package rc4_pkg;

    localparam int BYTE_W = 8;

    // Opcode of an input word
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_DATA = 1'b1;

    // Last entry of the permutation
    localparam logic [BYTE_W-1:0] PERM_LAST = 8'hFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_RD_I,
        ST_RD_J,
        ST_WR_I,
        ST_WR_J,
        ST_RD_T,
        ST_EMIT
    } t_state;

    // Commands from the sequencer to the key store
    typedef struct packed {
        logic load;     // store a key byte at the fill count
        logic restart;  // key index back to the first byte
        logic advance;  // key index to the next byte, wrapping at the count
        logic clear;    // schedule finished: empty the store
    } t_key_cmd;

endpackage

`default_nettype wire

FILE: hdl/rc4_stream_cipher_unit.sv
// RC4 stream cipher.
// Input channel (i_valid/o_ready): i_opcode selects a key word (0) or a data
// word (1), i_value carries the byte, i_last marks the final key byte (which
// starts the key schedule) or the final byte of a message.
// Output channel (o_valid/i_ready): one word per data byte, o_out_byte is the
// byte XOR keystream, o_error is set (with a zero byte) for data that comes
// before a key has been scheduled.
// Key words produce nothing; a key byte without last is stored and the block
// stays idle. A last key byte runs the schedule with o_ready low: a fill of
// all 256 permutation entries, then 256 swap steps through ST_RD_I, ST_RD_J,
// ST_WR_I and ST_WR_J. A keyed data byte goes through these, then ST_RD_T and
// ST_EMIT to the output register, an unkeyed one through ST_EMIT only; the
// next word is taken in ST_IDLE only. Per keyed byte the permutation memory
// (one read and one write port) sees three reads and two writes.
// A result waits in the output register while the receiver stalls; the next
// key word is still accepted, the next data word is taken and then waits in
// the sequencer for the slot, with o_ready low.
// Reset empties the key store, clears the indices and leaves the block
// unkeyed; the memory contents are not cleared.
`default_nettype none

`include "rc4_stream_cipher_unit_macros.svh"

module rc4_stream_cipher_unit #(
    parameter int KEY_MAX = 256
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_ready,
    input  wire                        i_opcode,
    input  wire [rc4_pkg::BYTE_W-1:0]  i_value,
    input  wire                        i_last,
    output logic                       o_valid,
    input  wire                        i_ready,
    output logic [rc4_pkg::BYTE_W-1:0] o_out_byte,
    output logic                       o_error
);
    import rc4_pkg::*;

    t_state            r_state, n_state;
    logic [BYTE_W-1:0] r_i, n_i;
    logic [BYTE_W-1:0] r_j, n_j;
    logic              r_keyed, n_keyed;
    logic              r_sched, n_sched;
    logic              r_o_valid, n_o_valid;
    logic [BYTE_W-1:0] r_si, n_si;
    logic [BYTE_W-1:0] r_sj, n_sj;
    logic [BYTE_W-1:0] r_val, n_val;
    logic              r_last, n_last;
    logic              r_fwd, n_fwd;
    logic [BYTE_W-1:0] r_res_byte, n_res_byte;
    logic              r_res_err, n_res_err;
    logic [BYTE_W-1:0] r_obyte, n_obyte;
    logic              r_oerr, n_oerr;

    logic [BYTE_W-1:0] r_perm [1 << BYTE_W];
    logic [BYTE_W-1:0] r_perm_q;
    logic              perm_we;
    logic [BYTE_W-1:0] perm_waddr, perm_wdata, perm_raddr;

    t_key_cmd          key_cmd;
    logic [BYTE_W-1:0] key_byte;
    logic [BYTE_W-1:0] j_sum, t_idx, ks;

    rc4_keystore #(
        .KEY_MAX (KEY_MAX)
    ) u_keystore (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (key_cmd),
        .i_key_byte (i_value),
        .o_key_byte (key_byte)
    );

    // Permutation memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (perm_we) begin
            r_perm[perm_waddr] <= perm_wdata;
        end
        r_perm_q <= r_perm[perm_raddr];
    end

    assign j_sum = r_j + r_perm_q + (r_sched ? key_byte : '0);
    assign t_idx = r_si + r_sj;
    assign ks    = r_fwd ? r_si : r_perm_q;

    // Sequence key loading, schedule steps and keystream steps
    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_j        = r_j;
        n_keyed    = r_keyed;
        n_sched    = r_sched;
        n_o_valid  = r_o_valid;
        n_si       = r_si;
        n_sj       = r_sj;
        n_val      = r_val;
        n_last     = r_last;
        n_fwd      = r_fwd;
        n_res_byte = r_res_byte;
        n_res_err  = r_res_err;
        n_obyte    = r_obyte;
        n_oerr     = r_oerr;
        perm_we    = 1'b0;
        perm_waddr = r_i;
        perm_wdata = r_i;
        perm_raddr = r_i;
        key_cmd    = '0;
        o_ready    = (r_state == ST_IDLE);

        // Drop the output word once taken
        if (i_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_opcode == OP_KEY) begin
                        key_cmd.load = 1'b1;
                        if (i_last) begin
                            key_cmd.restart = 1'b1;
                            n_i     = '0;
                            n_j     = '0;
                            n_sched = 1'b1;
                            n_state = ST_FILL;
                        end
                    end else if (r_keyed) begin
                        n_i     = r_i + BYTE_W'(1);
                        n_val   = i_value;
                        n_last  = i_last;
                        n_state = ST_RD_I;
                    end else begin
                        n_res_byte = '0;
                        n_res_err  = 1'b1;
                        n_state    = ST_EMIT;
                    end
                end
            end
            ST_FILL: begin
                // Identity permutation, one entry a cycle
                perm_we = 1'b1;
                n_i     = r_i + BYTE_W'(1);
                if (r_i == PERM_LAST) begin
                    n_state = ST_RD_I;
                end
            end
            ST_RD_I: begin
                n_state = ST_RD_J;
            end
            ST_RD_J: begin
                n_si       = r_perm_q;
                n_j        = j_sum;
                perm_raddr = j_sum;
                n_state    = ST_WR_I;
            end
            ST_WR_I: begin
                perm_we    = 1'b1;
                perm_wdata = r_perm_q;
                n_sj       = r_perm_q;
                n_state    = ST_WR_J;
            end
            ST_WR_J: begin
                perm_we    = 1'b1;
                perm_waddr = r_j;
                perm_wdata = r_si;
                if (r_sched) begin
                    key_cmd.advance = 1'b1;
                    if (r_i == PERM_LAST) begin
                        key_cmd.clear = 1'b1;
                        n_i     = '0;
                        n_j     = '0;
                        n_keyed = 1'b1;
                        n_sched = 1'b0;
                        n_state = ST_IDLE;
                    end else begin
                        n_i     = r_i + BYTE_W'(1);
                        n_state = ST_RD_I;
                    end
                end else begin
                    // The write to S[j] lands this cycle: forward it if hit
                    perm_raddr = t_idx;
                    n_fwd      = (t_idx == r_j);
                    n_state    = ST_RD_T;
                end
            end
            ST_RD_T: begin
                n_res_byte = r_val ^ ks;
                n_res_err  = 1'b0;
                if (r_last) begin
                    n_keyed = 1'b0;
                end
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                // Hold until the output register is free
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_obyte   = r_res_byte;
                    n_oerr    = r_res_err;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_i       <= '0;
            r_j       <= '0;
            r_keyed   <= 1'b0;
            r_sched   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_i       <= n_i;
            r_j       <= n_j;
            r_keyed   <= n_keyed;
            r_sched   <= n_sched;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_si       <= n_si;
        r_sj       <= n_sj;
        r_val      <= n_val;
        r_last     <= n_last;
        r_fwd      <= n_fwd;
        r_res_byte <= n_res_byte;
        r_res_err  <= n_res_err;
        r_obyte    <= n_obyte;
        r_oerr     <= n_oerr;
    end

    assign o_valid    = r_o_valid;
    assign o_out_byte = r_obyte;
    assign o_error    = r_oerr;

    `RC4_ASSERT_IMP(a_err_zero, o_valid && o_error, o_out_byte == '0, "error word with nonzero byte")
    `RC4_ASSERT_IMP(a_data_keyed, (r_state == ST_RD_I) && !r_sched, r_keyed, "keystream step while unkeyed")
    `RC4_ASSERT_NXT(a_sched_done, (r_state == ST_WR_J) && r_sched && (r_i == PERM_LAST), r_keyed && (r_i == '0) && (r_j == '0), "schedule end left bad state")

endmodule

`default_nettype wire

FILE: hdl/rc4_keystore.sv
`default_nettype none

`include "rc4_stream_cipher_unit_macros.svh"

module rc4_keystore #(
    parameter int KEY_MAX = 256
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire rc4_pkg::t_key_cmd   i_cmd,
    input  wire [rc4_pkg::BYTE_W-1:0] i_key_byte,
    output logic [rc4_pkg::BYTE_W-1:0] o_key_byte
);
    import rc4_pkg::*;

    localparam int CW = $clog2(KEY_MAX + 1);
    localparam int KW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

    logic [BYTE_W-1:0] r_key [KEY_MAX];
    logic [BYTE_W-1:0] r_key_q;
    logic [CW-1:0]     r_kcnt, n_kcnt;
    logic [KW-1:0]     r_kidx, n_kidx;
    logic [CW-1:0]     kidx_inc;
    logic              room;

    assign room     = (r_kcnt < CW'(KEY_MAX));
    assign kidx_inc = CW'(r_kidx) + CW'(1);

    // Key bytes past the limit are dropped
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && room) begin
            r_key[r_kcnt[KW-1:0]] <= i_key_byte;
        end
        r_key_q <= r_key[r_kidx];
    end

    assign o_key_byte = r_key_q;

    // Fill count and schedule index
    always_comb begin
        n_kcnt = r_kcnt;
        n_kidx = r_kidx;
        if (i_cmd.load && room) begin
            n_kcnt = r_kcnt + CW'(1);
        end
        if (i_cmd.restart) begin
            n_kidx = '0;
        end
        if (i_cmd.advance) begin
            n_kidx = (kidx_inc >= r_kcnt) ? '0 : kidx_inc[KW-1:0];
        end
        if (i_cmd.clear) begin
            n_kcnt = '0;
            n_kidx = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kcnt <= '0;
            r_kidx <= '0;
        end else begin
            r_kcnt <= n_kcnt;
            r_kidx <= n_kidx;
        end
    end

    `RC4_ASSERT_IMP(a_kcnt_bound, 1'b1, r_kcnt <= CW'(KEY_MAX), "key count over limit")
    `RC4_ASSERT_IMP(a_kidx_bound, 1'b1, CW'(r_kidx) < CW'(KEY_MAX), "key index out of range")
    `RC4_ASSERT_NXT(a_kidx_wrap, i_cmd.advance && !i_cmd.clear && (kidx_inc >= r_kcnt), r_kidx == '0, "key index failed to wrap")

endmodule

`default_nettype wire
